// File: src/http_request_header_tokenizer_defines.svh
// Assertion macros for the request header tokenizer.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define HRHT_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define HRHT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check that a condition implies another in the same cycle.
`define HRHT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define HRHT_CHECK(lbl, cond, msg)
`define HRHT_NEXT(lbl, ante, cons, msg)
`define HRHT_SAME(lbl, ante, cons, msg)

`endif

`endif

// File: src/hrht_pkg.sv
// Types, constants and per-byte helper functions of the request header tokenizer.
`timescale 1ns / 1ps

package hrht_pkg;

	// Byte codes
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Buffer limits and block size
	localparam int METHOD_BUF     = 16;
	localparam int PATH_BUF       = 256;
	localparam int HEADER_CAP_DEF = 32;
	localparam int BLOCK_MAX      = 65535;
	localparam int OUTQ_DEPTH_DEF = 4;

	localparam logic [16:0] OFF_LIMIT = (BLOCK_MAX < 65535) ? 17'(BLOCK_MAX) : 17'(65535);
	localparam logic [15:0] METHOD_LIM = 16'(METHOD_BUF);
	localparam logic [15:0] PATH_LIM   = 16'(PATH_BUF);

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_PATH_LEAD,
		PH_PATH,
		PH_REQ_REST,
		PH_NAME,
		PH_VAL_LEAD,
		PH_VAL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_REQ,
		KIND_HDR,
		KIND_FIN_OK,
		KIND_FIN_BAD
	} kind_t;

	// Parser state apart from the header counter
	typedef struct packed {
		phase_t      phase;
		logic        pcr;
		logic [15:0] off;
		logic [15:0] a_s;
		logic [15:0] a_l;
		logic [15:0] b_s;
		logic [15:0] b_l;
		logic        colon;
		logic        failed;
	} st_t;

	// One result beat
	typedef struct packed {
		kind_t       kind;
		logic [15:0] a0;
		logic [15:0] a1;
		logic [15:0] b0;
		logic [15:0] b1;
		logic [4:0]  slot;
		logic [5:0]  total;
		logic        fin;
	} rec_t;

	localparam st_t ST_RESET = '{
		phase:  PH_METHOD,
		pcr:    1'b0,
		off:    16'd0,
		a_s:    16'd0,
		a_l:    16'd0,
		b_s:    16'd0,
		b_l:    16'd0,
		colon:  1'b0,
		failed: 1'b0
	};

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB);
	endfunction

	// Advance the token trackers by one byte that is not a line end
	function automatic st_t ordinary(input st_t s, input logic [7:0] c, input logic [15:0] off);
		st_t r;
		r = s;
		case (s.phase)
			PH_METHOD: begin
				if (c == CH_SP) begin
					r.a_l   = off;
					r.phase = PH_PATH_LEAD;
				end
			end
			PH_PATH_LEAD: begin
				if (c != CH_SP) begin
					r.b_s   = off;
					r.phase = PH_PATH;
				end
			end
			PH_PATH: begin
				if (c == CH_SP) begin
					r.b_l   = off;
					r.phase = PH_REQ_REST;
				end
			end
			PH_NAME: begin
				if (c == CH_COLON) begin
					r.colon = 1'b1;
					r.phase = PH_VAL_LEAD;
				end else if (!is_blank(c)) begin
					r.a_l = off + 16'd1;
				end
			end
			PH_VAL_LEAD: begin
				if (!is_blank(c)) begin
					r.b_s   = off;
					r.b_l   = off + 16'd1;
					r.phase = PH_VAL;
				end
			end
			PH_VAL: begin
				if (!is_blank(c)) r.b_l = off + 16'd1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Open a header line that starts after the CR LF at cr
	function automatic st_t next_line(input st_t s, input logic [15:0] cr);
		st_t r;
		r       = s;
		r.a_s   = cr + 16'd2;
		r.a_l   = cr + 16'd2;
		r.b_s   = 16'd0;
		r.b_l   = 16'd0;
		r.colon = 1'b0;
		r.phase = PH_NAME;
		return r;
	endfunction

endpackage

// File: src/hrht_parse.sv
// Byte parser: line and token tracking, request and header records, finish record.
`timescale 1ns / 1ps

module hrht_parse import hrht_pkg::*; #(
	parameter int HEADER_CAP = HEADER_CAP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       block_end,
	output logic       rec0_v,
	output rec_t       rec0,
	output logic       rec1_v,
	output rec_t       rec1
);

	localparam int CNT_W = $clog2(HEADER_CAP + 1);
	localparam int CW    = (CNT_W > 6) ? CNT_W : 6;

	st_t              st_q, st_d, s, pre;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      off, cr, mlen, plen, vs, ve;
	logic             do_store;
	logic [CW-1:0]    slot_ext, total_ext;

	// Hold parser state; advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_RESET;
			cnt_q <= '0;
		end else if (fire) begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
		end
	end

	// Work out next state and the records that this byte causes
	always_comb begin
		s         = st_q;
		pre       = st_q;
		cnt_d     = cnt_q;
		off       = st_q.off;
		cr        = st_q.off - 16'd1;
		mlen      = st_q.a_l - st_q.a_s;
		plen      = st_q.b_l - st_q.b_s;
		vs        = cr;
		ve        = cr;
		do_store  = 1'b0;
		rec0_v    = 1'b0;
		rec0      = '0;
		rec1_v    = 1'b0;
		rec1      = '0;
		slot_ext  = CW'(cnt_q);
		total_ext = CW'(cnt_q);

		if ({1'b0, off} < OFF_LIMIT) begin
			if (st_q.pcr) begin
				s.pcr = 1'b0;
				if (data_byte == CH_LF) begin
					// Line end at the pending CR
					unique case (s.phase) inside
						PH_METHOD, PH_PATH_LEAD, PH_PATH: begin
							s.failed = 1'b1;
							s.phase  = PH_DONE;
						end
						PH_REQ_REST: begin
							if (mlen == 16'd0 || mlen >= METHOD_LIM ||
							    plen == 16'd0 || plen >= PATH_LIM) begin
								s.failed = 1'b1;
								s.phase  = PH_DONE;
							end else begin
								rec0_v    = 1'b1;
								rec0.kind = KIND_REQ;
								rec0.a0   = pre.a_s;
								rec0.a1   = pre.a_l;
								rec0.b0   = pre.b_s;
								rec0.b1   = pre.b_l;
								s         = next_line(s, cr);
							end
						end
						PH_NAME: begin
							if (cr == s.a_s) s.phase = PH_DONE;
							else s = next_line(s, cr);
						end
						PH_VAL_LEAD: begin
							do_store = 1'b1;
							s        = next_line(s, cr);
						end
						PH_VAL: begin
							do_store = 1'b1;
							vs       = pre.b_s;
							ve       = pre.b_l;
							s        = next_line(s, cr);
						end
						default: begin
						end
					endcase
				end else begin
					s = ordinary(s, CH_CR, cr);
					if (data_byte == CH_CR) s.pcr = 1'b1;
					else s = ordinary(s, data_byte, off);
				end
			end else if (data_byte == CH_CR) begin
				s.pcr = 1'b1;
			end else begin
				s = ordinary(s, data_byte, off);
			end
			s.off = off + 16'd1;
		end

		// Store a header with a non-empty name while the table has room
		if (do_store && pre.a_l > pre.a_s && cnt_q < CNT_W'(HEADER_CAP)) begin
			cnt_d      = cnt_q + CNT_W'(1);
			total_ext  = CW'(cnt_d);
			rec0_v     = 1'b1;
			rec0.kind  = KIND_HDR;
			rec0.a0    = pre.a_s;
			rec0.a1    = pre.a_l;
			rec0.b0    = vs;
			rec0.b1    = ve;
			rec0.slot  = slot_ext[4:0];
			rec0.total = total_ext[5:0];
		end

		// Finish the block on its last byte and drop back to the reset state
		if (block_end) begin
			rec1_v     = 1'b1;
			rec1.kind  = (s.failed || s.phase < PH_NAME) ? KIND_FIN_BAD : KIND_FIN_OK;
			total_ext  = CW'(cnt_d);
			rec1.total = total_ext[5:0];
			rec1.fin   = 1'b1;
			s          = ST_RESET;
			cnt_d      = '0;
		end

		st_d = s;
	end

endmodule

// File: src/hrht_outq.sv
// Output queue of result beats: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module hrht_outq import hrht_pkg::*; #(
	parameter int DEPTH = OUTQ_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push0,
	input  logic                       push1,
	input  rec_t                       d0,
	input  rec_t                       d1,
	input  logic                       pop,
	output rec_t                       head,
	output logic                       nonempty,
	output logic                       room,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp1, wp2, rp1;
	logic [LW-1:0] lvl_q, lvl_d;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1 = wrap_inc(wp_q);
	assign wp2 = wrap_inc(wp1);
	assign rp1 = wrap_inc(rp_q);

	// Count entries after this cycle's writes and read
	always_comb begin
		lvl_d = lvl_q;
		if (push0) lvl_d = lvl_d + LW'(1);
		if (push1) lvl_d = lvl_d + LW'(1);
		if (pop)   lvl_d = lvl_d - LW'(1);
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			lvl_q <= '0;
		end else begin
			lvl_q <= lvl_d;
			if (push1) wp_q <= wp2;
			else if (push0) wp_q <= wp1;
			if (pop) rp_q <= rp1;
		end
	end

	// Write beats into storage
	always_ff @(posedge clk) begin
		if (push0) mem_q[wp_q] <= d0;
		if (push1) mem_q[wp1]  <= d1;
	end

	assign head     = mem_q[rp_q];
	assign nonempty = (lvl_q != '0);
	assign room     = (lvl_q <= LW'(DEPTH - 2));
	assign level    = lvl_q;

endmodule

// File: src/http_request_header_tokenizer.sv
// Each result beat is written into the output queue when its input beat is accepted and is offered from the queue head.
// Throughput: one input byte per cycle; a byte causes at most two result beats, which
// leave the output queue one per cycle while out_stall is low; input stalls while fewer
// than two queue entries are free.
// Reset: arst_n clears parser state, header count and queue pointers at once.
`timescale 1ns / 1ps

`include "http_request_header_tokenizer_defines.svh"

module http_request_header_tokenizer import hrht_pkg::*; #(
	parameter int HEADER_CAP = HEADER_CAP_DEF,
	parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        block_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [15:0] first_start,
	output logic [15:0] first_stop,
	output logic [15:0] second_start,
	output logic [15:0] second_stop,
	output logic [4:0]  slot_index,
	output logic [5:0]  header_total,
	output logic        final_record
);

	logic                            fire, rec0_v, rec1_v, room, pop, fin_kind;
	rec_t                            rec0, rec1, head;
	logic [$clog2(OUTQ_DEPTH+1)-1:0] level;

	assign in_stall = !room;
	assign fire     = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	hrht_parse #(
		.HEADER_CAP (HEADER_CAP)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_byte),
		.block_end (block_end),
		.rec0_v    (rec0_v),
		.rec0      (rec0),
		.rec1_v    (rec1_v),
		.rec1      (rec1)
	);

	// Queue the record beat first, then the finish beat
	hrht_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (fire && (rec0_v || rec1_v)),
		.push1    (fire && rec0_v && rec1_v),
		.d0       (rec0_v ? rec0 : rec1),
		.d1       (rec1),
		.pop      (pop),
		.head     (head),
		.nonempty (out_valid),
		.room     (room),
		.level    (level)
	);

	assign record_kind  = head.kind;
	assign first_start  = head.a0;
	assign first_stop   = head.a1;
	assign second_start = head.b0;
	assign second_stop  = head.b1;
	assign slot_index   = head.slot;
	assign header_total = head.total;
	assign final_record = head.fin;

	// Flag the finish kinds on the head beat
	assign fin_kind = (record_kind == KIND_FIN_OK) || (record_kind == KIND_FIN_BAD);

	`HRHT_CHECK(a_level_bound, level <= ($clog2(OUTQ_DEPTH+1))'(OUTQ_DEPTH), "queue overfilled")
	`HRHT_NEXT(a_finish_queued, in_valid && !in_stall && block_end, out_valid, "finish beat lost")
	`HRHT_SAME(a_final_kind, out_valid, final_record == fin_kind, "final flag and kind disagree")

endmodule
